// ===== rtl/gqi_pkg.sv =====
// ----------------------------------------------------------------------------
// gqi_pkg
// Types and constants shared by the quaternion gyro integrator modules.
// ----------------------------------------------------------------------------
package gqi_pkg;

   localparam int Q_W     = 32;  // quaternion component, Q2.30
   localparam int H_W     = 45;  // half-angle step, Q.30
   localparam int H_LO_W  = 30;  // low part of h, unsigned
   localparam int H_SHIFT = 19;  // Q16.48 rate*dt down to Q.30 with the half
   localparam int MUL_W   = 33;  // shared multiplier operand width
   localparam int PROD_W  = 2 * MUL_W;
   localparam int ACC_W   = 52;  // component plus six partial products

   localparam logic signed [Q_W-1:0]   Q_ONE    = 32'sh4000_0000;
   localparam logic        [31:0]      DT_RESET = 32'd4294967;
   localparam logic signed [ACC_W-1:0] Q_MAX    = {{(ACC_W-Q_W){1'b0}}, 32'h7FFF_FFFF};
   localparam logic signed [ACC_W-1:0] Q_MIN    = {{(ACC_W-Q_W){1'b1}}, 32'h8000_0000};

   localparam logic KIND_GYRO = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   typedef struct packed {
      logic       valid;
      logic       first;   // start of a component: base is the old value
      logic       last;    // final partial product of a component
      logic       neg;
      logic       shift;   // low-part product: floor by 2^30
      logic [1:0] comp;
   } acc_ctrl_type;

   typedef struct packed {
      logic                 valid;
      logic [1:0]           comp;
      logic signed [Q_W-1:0] value;
      logic                 sat;
   } acc_res_type;

   typedef struct packed {
      logic [1:0] q_idx;
      logic [1:0] h_idx;
      logic       neg;
   } term_type;

   // Product terms of q' = q + q (x) (0, h), component order w x y z
   function automatic term_type term_sel(input logic [1:0] comp, input logic [1:0] term);
      term_type t;
      case ({comp, term})
         4'b00_00: t = '{q_idx: 2'd1, h_idx: 2'd0, neg: 1'b1};
         4'b00_01: t = '{q_idx: 2'd2, h_idx: 2'd1, neg: 1'b1};
         4'b00_10: t = '{q_idx: 2'd3, h_idx: 2'd2, neg: 1'b1};
         4'b01_00: t = '{q_idx: 2'd0, h_idx: 2'd0, neg: 1'b0};
         4'b01_01: t = '{q_idx: 2'd2, h_idx: 2'd2, neg: 1'b0};
         4'b01_10: t = '{q_idx: 2'd3, h_idx: 2'd1, neg: 1'b1};
         4'b10_00: t = '{q_idx: 2'd0, h_idx: 2'd1, neg: 1'b0};
         4'b10_01: t = '{q_idx: 2'd1, h_idx: 2'd2, neg: 1'b1};
         4'b10_10: t = '{q_idx: 2'd3, h_idx: 2'd0, neg: 1'b0};
         4'b11_00: t = '{q_idx: 2'd0, h_idx: 2'd2, neg: 1'b0};
         4'b11_01: t = '{q_idx: 2'd1, h_idx: 2'd1, neg: 1'b0};
         4'b11_10: t = '{q_idx: 2'd2, h_idx: 2'd0, neg: 1'b1};
         default:  t = '{q_idx: 2'd0, h_idx: 2'd0, neg: 1'b0};
      endcase
      return t;
   endfunction

endpackage

// ===== rtl/quaternion_gyro_integrator_unit.sv =====
// ----------------------------------------------------------------------------
// quaternion_gyro_integrator_unit
// First-order quaternion integration of gyro rates in fixed point.
// ----------------------------------------------------------------------------
// Keeps an attitude quaternion (Q2.30, reset to identity) and advances it by
// q' = q + q (x) (0, h) for every gyro item, h = rate * time_step / 2, with
// each product floored and each component saturated to Q2.30. One 33x33
// multiplier is shared: it first forms the three parts of h, then the
// twelve products, each as a low-part and a high-part product of h. No new
// item is taken until the result of the previous one, gyro or load, has
// been registered for the output. A new item is accepted while the previous
// result is still waiting on the output.
// ----------------------------------------------------------------------------
module quaternion_gyro_integrator_unit
   import gqi_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_en,
   input  logic [31:0]  csr_write_data,   // time_step, unsigned Q0.32
   input  logic         req_tvalid,
   output logic         req_tready,
   // rate_x, rate_y, rate_z, load_w, load_x, load_y, load_z
   input  logic [223:0] req_tdata,
   input  logic         req_tuser,         // kind
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [127:0] rsp_tdata,         // quat_w, quat_x, quat_y, quat_z
   output logic         rsp_tuser          // saturated
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_HSTEP,
      S_QSTEP,
      S_DRAIN,
      S_DONE
   } state_type;

   state_type state_ff;

   logic        [31:0]      time_step_ff;
   logic signed [Q_W-1:0]   q_ff   [4];
   logic signed [Q_W-1:0]   nq_ff  [4];
   logic signed [Q_W-1:0]   rate_ff[3];
   logic signed [H_W-1:0]   h_ff   [3];
   logic                    sat_ff;
   logic [1:0]              hidx_ff;
   logic [1:0]              comp_ff;
   logic [1:0]              term_ff;
   logic                    half_ff;
   logic                    rsp_valid_ff;
   logic [127:0]            rsp_data_ff;
   logic                    rsp_sat_ff;

   // tag travelling beside the multiplier's registered product
   logic                    hst_valid_ff;
   logic [1:0]              hst_idx_ff;
   acc_ctrl_type            actl_ff;
   acc_ctrl_type            actl_in;

   logic signed [MUL_W-1:0]  op_a;
   logic signed [MUL_W-1:0]  op_b;
   logic signed [PROD_W-1:0] prod;
   logic signed [Q_W-1:0]    q_sel;
   logic signed [H_W-1:0]    h_sel;
   logic signed [Q_W-1:0]    r_sel;
   term_type                 tsel;
   acc_res_type              res;
   logic                     req_fire;
   logic                     out_free;

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_sat_ff;

   assign tsel  = term_sel(comp_ff, term_ff);
   assign q_sel = q_ff[tsel.q_idx];
   assign h_sel = h_ff[tsel.h_idx];
   assign r_sel = rate_ff[hidx_ff];

   always_comb begin
      op_a    = '0;
      op_b    = '0;
      actl_in = '0;
      case (state_ff)
         S_HSTEP: begin
            op_a = {r_sel[Q_W-1], r_sel};
            op_b = {1'b0, time_step_ff};
         end
         S_QSTEP: begin
            op_a = {q_sel[Q_W-1], q_sel};
            if (half_ff) begin
               op_b = {{(MUL_W-(H_W-H_LO_W)){h_sel[H_W-1]}}, h_sel[H_W-1:H_LO_W]};
            end else begin
               op_b = {{(MUL_W-H_LO_W){1'b0}}, h_sel[H_LO_W-1:0]};
            end
            actl_in.valid = 1'b1;
            actl_in.first = (term_ff == 2'd0) && !half_ff;
            actl_in.last  = (term_ff == 2'd2) && half_ff;
            actl_in.neg   = tsel.neg;
            actl_in.shift = !half_ff;
            actl_in.comp  = comp_ff;
         end
         default: begin
         end
      endcase
   end

   gqi_mul u_mul (
      .clock   (clock),
      .op_a    (op_a),
      .op_b    (op_b),
      .prod_ff (prod)
   );

   gqi_acc u_acc (
      .clock  (clock),
      .ctrl   (actl_ff),
      .prod   (prod),
      .base_q (q_ff[actl_ff.comp]),
      .res    (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         time_step_ff <= DT_RESET;
         q_ff[0]      <= Q_ONE;
         q_ff[1]      <= '0;
         q_ff[2]      <= '0;
         q_ff[3]      <= '0;
         rsp_valid_ff <= 1'b0;
         hst_valid_ff <= 1'b0;
         actl_ff      <= '0;
         hidx_ff      <= '0;
         comp_ff      <= '0;
         term_ff      <= '0;
         half_ff      <= 1'b0;
         sat_ff       <= 1'b0;
      end else begin
         if (csr_write_en) begin
            time_step_ff <= csr_write_data;
         end
         if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         hst_valid_ff <= (state_ff == S_HSTEP);
         hst_idx_ff   <= hidx_ff;
         actl_ff      <= actl_in;

         if (hst_valid_ff) begin
            h_ff[hst_idx_ff] <= prod[H_SHIFT+H_W-1:H_SHIFT];
         end
         if (res.valid) begin
            nq_ff[res.comp] <= res.value;
            sat_ff          <= sat_ff | res.sat;
         end

         case (state_ff)
            S_IDLE: begin
               if (req_fire) begin
                  sat_ff     <= 1'b0;
                  rate_ff[0] <= req_tdata[31:0];
                  rate_ff[1] <= req_tdata[63:32];
                  rate_ff[2] <= req_tdata[95:64];
                  hidx_ff    <= '0;
                  if (req_tuser == KIND_LOAD) begin
                     nq_ff[0] <= req_tdata[127:96];
                     nq_ff[1] <= req_tdata[159:128];
                     nq_ff[2] <= req_tdata[191:160];
                     nq_ff[3] <= req_tdata[223:192];
                     state_ff <= S_DONE;
                  end else begin
                     state_ff <= S_HSTEP;
                  end
               end
            end
            S_HSTEP: begin
               if (hidx_ff == 2'd2) begin
                  comp_ff  <= '0;
                  term_ff  <= '0;
                  half_ff  <= 1'b0;
                  state_ff <= S_QSTEP;
               end else begin
                  hidx_ff <= hidx_ff + 2'd1;
               end
            end
            S_QSTEP: begin
               half_ff <= !half_ff;
               if (half_ff) begin
                  if (term_ff == 2'd2) begin
                     term_ff <= '0;
                     comp_ff <= comp_ff + 2'd1;
                     if (comp_ff == 2'd3) begin
                        state_ff <= S_DRAIN;
                     end
                  end else begin
                     term_ff <= term_ff + 2'd1;
                  end
               end
            end
            S_DRAIN: begin
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (out_free) begin
                  q_ff         <= nq_ff;
                  rsp_data_ff  <= {nq_ff[3], nq_ff[2], nq_ff[1], nq_ff[0]};
                  rsp_sat_ff   <= sat_ff;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

// ===== rtl/gqi_mul.sv =====
// ----------------------------------------------------------------------------
// gqi_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module gqi_mul
   import gqi_pkg::*;
(
   input  logic                     clock,
   input  logic signed [MUL_W-1:0]  op_a,
   input  logic signed [MUL_W-1:0]  op_b,
   output logic signed [PROD_W-1:0] prod_ff
);

   always_ff @(posedge clock) begin
      prod_ff <= op_a * op_b;
   end

endmodule

// ===== rtl/gqi_acc.sv =====
// ----------------------------------------------------------------------------
// gqi_acc
// Accumulates signed partial products into one component and clips it.
// ----------------------------------------------------------------------------
module gqi_acc
   import gqi_pkg::*;
(
   input  logic                     clock,
   input  acc_ctrl_type             ctrl,
   input  logic signed [PROD_W-1:0] prod,
   input  logic signed [Q_W-1:0]    base_q,
   output acc_res_type              res
);

   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  base;
   logic signed [ACC_W-1:0]  addend;
   logic signed [PROD_W-1:0] prod_sh;

   assign prod_sh = prod >>> H_LO_W;
   assign addend  = ctrl.shift ? prod_sh[ACC_W-1:0] : prod[ACC_W-1:0];
   assign base    = ctrl.first ? {{(ACC_W-Q_W){base_q[Q_W-1]}}, base_q} : acc_ff;
   assign acc_in  = ctrl.neg ? base - addend : base + addend;

   always_ff @(posedge clock) begin
      if (ctrl.valid) begin
         acc_ff <= acc_in;
      end
   end

   always_comb begin
      res.valid = ctrl.valid && ctrl.last;
      res.comp  = ctrl.comp;
      res.sat   = 1'b0;
      if (acc_in > Q_MAX) begin
         res.value = Q_MAX[Q_W-1:0];
         res.sat   = 1'b1;
      end else if (acc_in < Q_MIN) begin
         res.value = Q_MIN[Q_W-1:0];
         res.sat   = 1'b1;
      end else begin
         res.value = acc_in[Q_W-1:0];
      end
   end

endmodule
